// ===== hdl/btl_pkg.sv =====
// Shared types for the boot tape block loader: phase codes, loader state
// and the result record. No dependencies.
package btl_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_LOAD_HI = 4'd1,
    PH_LOAD_LO = 4'd2,
    PH_CNT_HI  = 4'd3,
    PH_CNT_LO  = 4'd4,
    PH_DATA_HI = 4'd5,
    PH_DATA_LO = 4'd6,
    PH_CK_HI   = 4'd7,
    PH_CK_LO   = 4'd8,
    PH_ACT_HI  = 4'd9,
    PH_ACT_LO  = 4'd10
  } phase_t;

  localparam logic [6:0] CHAR_BANG = 7'h21;
  localparam logic [6:0] CHAR_LF   = 7'h0a;
  localparam logic [6:0] CHAR_CR   = 7'h0d;
  // Upper four bits shared by the ASCII codes '0' through '7'.
  localparam logic [3:0] OCTAL_HI  = 4'b0110;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] octal_accum;
    logic [15:0] start_value;
    logic [7:0]  high_byte;
    logic [15:0] load_base;
    logic [15:0] words_left;
    logic [15:0] word_index;
    logic [15:0] running_sum;
    logic [15:0] checksum_seen;
  } btl_state_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_data;
    logic        load_done;
    logic        checksum_error;
    logic [15:0] start_address;
    logic [15:0] action_code;
  } btl_result_t;

endpackage

// ===== hdl/btl_byte_if.sv =====
// Tape byte channel: valid/ready handshake carrying one raw tape byte.
// No dependencies.
interface btl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;

  modport source (output valid, output tape_byte, input ready);
  modport sink   (input valid, input tape_byte, output ready);
endinterface

// ===== hdl/btl_result_if.sv =====
// Result channel: valid/ready handshake carrying one loader result.
// No dependencies.
interface btl_result_if;
  logic        valid;
  logic        ready;
  logic        mem_write;
  logic [15:0] mem_address;
  logic [15:0] mem_data;
  logic        load_done;
  logic        checksum_error;
  logic [15:0] start_address;
  logic [15:0] action_code;

  modport source (output valid, output mem_write, output mem_address, output mem_data,
                  output load_done, output checksum_error, output start_address,
                  output action_code, input ready);
  modport sink   (input valid, input mem_write, input mem_address, input mem_data,
                  input load_done, input checksum_error, input start_address,
                  input action_code, output ready);
endinterface

// ===== hdl/btl_step.sv =====
// Next-state and result logic for one tape byte.
// Depends on btl_pkg.
module btl_step
  import btl_pkg::*;
(
  input  btl_state_t  cur,
  input  logic [7:0]  tape_byte,
  output btl_state_t  nxt,
  output btl_result_t res
);

  logic [6:0]  c;
  logic [15:0] word;

  assign c    = tape_byte[6:0];
  assign word = {cur.high_byte, tape_byte};

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_LOAD_HI, PH_CNT_HI, PH_DATA_HI, PH_CK_HI, PH_ACT_HI: begin
        nxt.high_byte = tape_byte;
        nxt.phase     = phase_t'(cur.phase + 4'd1);
      end
      PH_LOAD_LO: begin
        nxt.load_base = word;
        nxt.phase     = PH_CNT_HI;
      end
      PH_CNT_LO: begin
        nxt.words_left  = word;
        nxt.word_index  = '0;
        nxt.running_sum = '0;
        nxt.phase       = (word == 16'd0) ? PH_CK_HI : PH_DATA_HI;
      end
      PH_DATA_LO: begin
        res.mem_write   = 1'b1;
        res.mem_address = cur.load_base + cur.word_index;
        res.mem_data    = word;
        nxt.running_sum = cur.running_sum + word;
        nxt.word_index  = cur.word_index + 16'd1;
        nxt.words_left  = cur.words_left - 16'd1;
        nxt.phase       = (cur.words_left == 16'd1) ? PH_CK_HI : PH_DATA_HI;
      end
      PH_CK_LO: begin
        nxt.checksum_seen = word;
        nxt.phase         = PH_ACT_HI;
      end
      PH_ACT_LO: begin
        res.load_done      = 1'b1;
        res.checksum_error = (cur.checksum_seen != cur.running_sum);
        res.start_address  = cur.start_value;
        res.action_code    = word;
        nxt.start_value    = '0;
        nxt.octal_accum    = '0;
        nxt.phase          = PH_HEADER;
      end
      default: begin
        // Header text; unused phase codes land here as well.
        nxt.phase = PH_HEADER;
        priority if (c == CHAR_BANG) begin
          nxt.octal_accum = '0;
          nxt.phase       = PH_LOAD_HI;
        end else if (c == CHAR_LF) begin
          nxt.octal_accum = cur.octal_accum;
        end else if (c == CHAR_CR) begin
          nxt.start_value = cur.octal_accum;
          nxt.octal_accum = '0;
        end else if (c[6:3] == OCTAL_HI) begin
          nxt.octal_accum = {cur.octal_accum[12:0], c[2:0]};
        end else begin
          nxt.start_value = '0;
          nxt.octal_accum = '0;
        end
      end
    endcase
  end

endmodule

// ===== hdl/boot_tape_block_loader_core.sv =====
// Top level of the boot tape block loader: input byte register, loader
// state, result register. Depends on btl_pkg, btl_byte_if, btl_result_if
// and btl_step.
//
// Usage:
//   tape   : sink of raw tape bytes, one request per byte.
//   result : source of results, exactly one result request per byte.
//   A byte accepted into the input register is decoded against the loader
//   state, and its result is registered in the result register and
//   presented on result until it is taken with result.ready high. Throughput
//   is one byte per cycle while the receiver does not stall: the only loop
//   is the update of the loader state registers through btl_step.
//   Data words appear as results with mem_write set; the action word
//   gives a result with load_done, checksum_error, start_address and
//   action_code. All other bytes give an all-zero result.
//   When the receiver stalls, the result register holds its request and
//   the input register stays full, so tape.ready drops until the
//   stall clears; nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) empties both registers and
//   returns the loader to header parsing with all state cleared.
module boot_tape_block_loader_core
  import btl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  btl_byte_if.sink     tape,
  btl_result_if.source result
);

  // Input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // Loader state
  btl_state_t  state;
  btl_state_t  state_next;
  btl_result_t step_res;

  // Result register
  logic        out_valid;
  btl_result_t out_res;

  logic        advance;

  // Move the held byte into the result register when that slot is free.
  assign advance    = !out_valid || result.ready;
  assign tape.ready = !in_valid || advance;

  btl_step u_step (
    .cur       (state),
    .tape_byte (in_byte),
    .nxt       (state_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tape.ready) begin
      in_valid <= tape.valid;
    end
    if (tape.ready) begin
      in_byte <= tape.tape_byte;
    end
  end

  // Commit the state only when the byte's result actually leaves the
  // input register, so a stall never advances the phase twice.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_HEADER;
      state.octal_accum   <= '0;
      state.start_value   <= '0;
      state.high_byte     <= '0;
      state.load_base     <= '0;
      state.words_left    <= '0;
      state.word_index    <= '0;
      state.running_sum   <= '0;
      state.checksum_seen <= '0;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_res <= step_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.mem_write      = out_res.mem_write;
  assign result.mem_address    = out_res.mem_address;
  assign result.mem_data       = out_res.mem_data;
  assign result.load_done      = out_res.load_done;
  assign result.checksum_error = out_res.checksum_error;
  assign result.start_address  = out_res.start_address;
  assign result.action_code    = out_res.action_code;

  // A store and a block end never come from the same byte.
  a_store_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.mem_write && out_res.load_done))
    else $error("store and load_done in one result");

  // A checksum error is only reported with the block end.
  a_error_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.checksum_error |-> out_res.load_done)
    else $error("checksum_error without load_done");

  // The action word returns the loader to header parsing.
  a_back_to_header: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && state.phase == PH_ACT_LO |=> state.phase == PH_HEADER)
    else $error("loader did not return to header after action word");

  // A byte in the input register moves into the result register when free.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> out_valid)
    else $error("result lost between registers");

endmodule

// ===== tb/tb_boot_tape_block_loader_core.sv =====
// Self-checking testbench for boot_tape_block_loader_core: tape bytes go in, and every
// result request is checked against a byte-level loader predictor.
// Depends on btl_pkg, btl_byte_if, btl_result_if and the RTL of the core.
module tb_boot_tape_block_loader_core;
  timeunit 1ns;
  timeprecision 1ps;

  import btl_pkg::*;

  // Scoreboard: tracks loader state byte by byte and holds the results still owed.
  class tape_loader_scoreboard;
    phase_t      phase;
    logic [15:0] octal_accum;
    logic [15:0] start_value;
    logic [7:0]  high_byte;
    logic [15:0] load_base;
    logic [15:0] words_left;
    logic [15:0] word_index;
    logic [15:0] running_sum;
    logic [15:0] checksum_seen;
    btl_result_t owed_results[$];
    int          errors;

    function new();
      phase         = PH_HEADER;
      octal_accum   = '0;
      start_value   = '0;
      high_byte     = '0;
      load_base     = '0;
      words_left    = '0;
      word_index    = '0;
      running_sum   = '0;
      checksum_seen = '0;
      errors        = 0;
    endfunction

    // Advance the loader on one accepted tape byte and queue the result it owes.
    function void note_byte(logic [7:0] b);
      btl_result_t r;
      logic [15:0] word;
      logic [6:0]  c;
      r    = '0;
      word = {high_byte, b};
      c    = b[6:0];
      case (phase)
        PH_LOAD_HI, PH_CNT_HI, PH_DATA_HI, PH_CK_HI, PH_ACT_HI: begin
          high_byte = b;
          phase     = phase_t'(phase + 4'd1);
        end
        PH_LOAD_LO: begin
          load_base = word;
          phase     = PH_CNT_HI;
        end
        PH_CNT_LO: begin
          words_left  = word;
          word_index  = '0;
          running_sum = '0;
          phase       = (word == 16'd0) ? PH_CK_HI : PH_DATA_HI;
        end
        PH_DATA_LO: begin
          r.mem_write   = 1'b1;
          r.mem_address = load_base + word_index;
          r.mem_data    = word;
          running_sum   = running_sum + word;
          word_index    = word_index + 16'd1;
          words_left    = words_left - 16'd1;
          phase         = (words_left == 16'd0) ? PH_CK_HI : PH_DATA_HI;
        end
        PH_CK_LO: begin
          checksum_seen = word;
          phase         = PH_ACT_HI;
        end
        PH_ACT_LO: begin
          r.load_done      = 1'b1;
          r.checksum_error = (checksum_seen != running_sum);
          r.start_address  = start_value;
          r.action_code    = word;
          start_value      = '0;
          octal_accum      = '0;
          phase            = PH_HEADER;
        end
        default: begin
          phase = PH_HEADER;
          if (c == CHAR_BANG) begin
            octal_accum = '0;
            phase       = PH_LOAD_HI;
          end else if (c == CHAR_LF) begin
          end else if (c == CHAR_CR) begin
            start_value = octal_accum;
            octal_accum = '0;
          end else if (c[6:3] == OCTAL_HI) begin
            octal_accum = {octal_accum[12:0], c[2:0]};
          end else begin
            start_value = '0;
            octal_accum = '0;
          end
        end
      endcase
      owed_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    // Compare one accepted result request with the oldest one owed.
    task check_result(btl_result_t got);
      btl_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", 16'(got.mem_write), 16'hxxxx);
        return;
      end
      want = owed_results.pop_front();
      if (got.mem_write !== want.mem_write)
        report_mismatch("mem_write", 16'(got.mem_write), 16'(want.mem_write));
      if (got.mem_address !== want.mem_address)
        report_mismatch("mem_address", got.mem_address, want.mem_address);
      if (got.mem_data !== want.mem_data)
        report_mismatch("mem_data", got.mem_data, want.mem_data);
      if (got.load_done !== want.load_done)
        report_mismatch("load_done", 16'(got.load_done), 16'(want.load_done));
      if (got.checksum_error !== want.checksum_error)
        report_mismatch("checksum_error", 16'(got.checksum_error), 16'(want.checksum_error));
      if (got.start_address !== want.start_address)
        report_mismatch("start_address", got.start_address, want.start_address);
      if (got.action_code !== want.action_code)
        report_mismatch("action_code", got.action_code, want.action_code);
    endtask
  endclass

  logic clk;
  logic rst;

  btl_byte_if   tape();
  btl_result_if result();

  boot_tape_block_loader_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .tape   (tape),
    .result (result)
  );

  tape_loader_scoreboard loader_sb;
  logic [7:0]            tape_q[$];
  int                    sender_calm_left;
  int                    receiver_calm_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("boot_tape_block_loader_core regression: fail");
    $finish;
  end

  // Draw a random idle gap; now and then enter a run of back-to-back requests.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0)
      calm_left = $urandom_range(10, 60);
    return $urandom_range(0, 15);
  endfunction

  // Set the ignored top bit at random, as a parity punch would.
  function automatic logic [7:0] punch(logic [6:0] c);
    return {1'($urandom_range(0, 1)), c};
  endfunction

  task automatic push_word(logic [15:0] w);
    tape_q.push_back(w[15:8]);
    tape_q.push_back(w[7:0]);
  endtask

  // Any byte except the header terminator, so noise stays in header parsing.
  task automatic push_noise(int count);
    logic [7:0] b;
    repeat (count) begin
      do b = 8'($urandom_range(0, 255)); while (b[6:0] == CHAR_BANG);
      tape_q.push_back(b);
    end
  endtask

  task automatic build_directed();
    // Header: a digit killed by a stray letter, then a seven-digit octal number
    // whose top bits fall off, taken by carriage return; line feeds with and
    // without the top bit; a trailing digit left pending when the header ends.
    tape_q.push_back("5");
    tape_q.push_back("X");
    tape_q.push_back("1");
    tape_q.push_back("7");
    tape_q.push_back(8'hB7);
    tape_q.push_back("7");
    tape_q.push_back("7");
    tape_q.push_back("7");
    tape_q.push_back("7");
    tape_q.push_back(8'h0D);
    tape_q.push_back(8'h0A);
    tape_q.push_back(8'h8A);
    tape_q.push_back("3");
    tape_q.push_back(8'hA1);
    // Block at the top of memory: the second store wraps to address zero.
    push_word(16'hFFFF);
    push_word(16'h0002);
    push_word(16'hFFFF);
    push_word(16'h1234);
    push_word(16'h1233);
    push_word(16'hFFFF);
    // Zero word count goes straight to the checksum; bad checksum, zero action.
    tape_q.push_back("!");
    push_word(16'h0000);
    push_word(16'h0000);
    push_word(16'h0001);
    push_word(16'h0000);
  endtask

  task automatic push_header();
    int digits;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          digits = $urandom_range(1, 8);
          repeat (digits) tape_q.push_back(punch(7'h30 + 7'($urandom_range(0, 7))));
          if ($urandom_range(0, 4) != 0) tape_q.push_back(punch(CHAR_CR));
        end
        6, 7: tape_q.push_back(punch(CHAR_LF));
        default: push_noise(1);
      endcase
    end
    tape_q.push_back(punch(CHAR_BANG));
  endtask

  task automatic push_block();
    logic [15:0] base;
    logic [15:0] count;
    logic [15:0] data;
    logic [15:0] sum;
    base = ($urandom_range(0, 3) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                        : 16'($urandom());
    case ($urandom_range(0, 19))
      0, 1:    count = 16'd0;
      2:       count = 16'($urandom_range(7, 40));
      default: count = 16'($urandom_range(1, 6));
    endcase
    push_word(base);
    push_word(count);
    sum = '0;
    repeat (count) begin
      data = 16'($urandom());
      sum  = sum + data;
      push_word(data);
    end
    push_word(($urandom_range(0, 4) != 0) ? sum : 16'($urandom()));
    push_word(($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom()));
  endtask

  task automatic build_random(int target);
    while (tape_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 12));
      push_header();
      push_block();
    end
  endtask

  // Offer one tape byte after a random idle gap; hold it until the core takes it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap(sender_calm_left);
    if (gap > 0) begin
      tape.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tape.valid     <= 1'b1;
    tape.tape_byte <= b;
    do @(posedge clk); while (tape.ready !== 1'b1);
    loader_sb.note_byte(b);
  endtask

  // Stimulus: reset, directed tape, then random blocks; finally drain and judge.
  initial begin
    rst            <= 1'b1;
    tape.valid     <= 1'b0;
    tape.tape_byte <= 8'h00;
    sender_calm_left   = 0;
    receiver_calm_left = 0;
    loader_sb = new();
    build_directed();
    build_random(tape_q.size() + 1500);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (tape_q.size() > 0) send_byte(tape_q.pop_front());
    tape.valid <= 1'b0;
    // Drain: wait for every owed result, then keep watching for strays.
    while (loader_sb.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (loader_sb.errors == 0 && loader_sb.owed_results.size() == 0)
      $display("boot_tape_block_loader_core regression: pass");
    else
      $display("boot_tape_block_loader_core regression: fail");
    $finish;
  end

  // Result side: stall at random, take each result request and check it.
  initial begin
    btl_result_t got;
    int          gap;
    result.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(receiver_calm_left);
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (result.valid !== 1'b1);
      got.mem_write      = result.mem_write;
      got.mem_address    = result.mem_address;
      got.mem_data       = result.mem_data;
      got.load_done      = result.load_done;
      got.checksum_error = result.checksum_error;
      got.start_address  = result.start_address;
      got.action_code    = result.action_code;
      loader_sb.check_result(got);
    end
  end

endmodule
